FILE: rtl/core/srms_pkg.sv
// Shared types and constants for the symmetric relation matrix store.
// Opcode codes, entry bit masks, field widths and the result layout.
// No dependencies.
`default_nettype none

package srms_pkg;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_SET_FWD = 3'd1,
    OP_SET_BWD = 3'd2,
    OP_QUERY   = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  localparam int unsigned ENTRY_W     = 3;
  localparam int unsigned ITEM_W      = 6;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [ENTRY_W-1:0] RELATED_BIT  = 3'h1;
  localparam logic [ENTRY_W-1:0] FORWARD_BIT  = 3'h2;
  localparam logic [ENTRY_W-1:0] BACKWARD_BIT = 3'h4;

  localparam logic [CFG_W-1:0]   ITEMS_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 11'h7FF;

  // Result beat, lowest bit first: error, related, forward, backward, count.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               bwd;
    logic               fwd;
    logic               rel;
    logic               err;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/srms_ram.sv
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered, so it appears in the cycle after the address.
// No dependencies.
`default_nettype none

module srms_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/symmetric_relation_matrix_store.sv
// Top level of the symmetric relation matrix store: sequencer, pair counter
// and output register around one entry RAM. Depends on srms_pkg and srms_ram.
//
//   channel   direction  fields (lowest bit first)
//   s_*       in         opcode[2:0], first_item[8:3], second_item[14:9]
//   m_*       out        range_error, is_related, forward_flag,
//                        backward_flag, related_pair_count[14:4]
//   cfg_*     in         items_in_use[6:0], written when cfg_we_i is high
//
// Path from accepted beat to result: a rejected or unused opcode goes straight
// to ST_OUT; a query passes ST_RD and ST_MOD; a pair add or flag passes ST_RD,
// ST_MOD and ST_MIR, and a row operation repeats these for each of its items.
// Each entry written costs a read and two writes through the RAM's single write
// port; a query only reads. Clear sweeps the RAM one entry a cycle, then goes
// to ST_OUT; after reset the same sweep runs before the first beat is taken. A
// stalled result waits in the output register as the next beat is accepted.
`default_nettype none

module symmetric_relation_matrix_store #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // opcode, first_item, second_item, zero fill
  input  logic [srms_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // range_error, is_related, forward_flag, backward_flag,
  // related_pair_count, zero fill
  output logic [srms_pkg::OUT_TDATA_W-1:0]   m_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [srms_pkg::CFG_W-1:0]         cfg_wdata_i
);

  import srms_pkg::*;

  localparam int unsigned DEPTH = MAX_ITEMS * MAX_ITEMS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LIM   = (MAX_ITEMS > 127) ? 127 : MAX_ITEMS;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_MOD,
    ST_MIR,
    ST_OUT
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        clr_q;
  logic                 pend_q;
  logic [CFG_W-1:0]     items_q;
  op_e                  op_q;
  logic [ITEM_W-1:0]    row_q;
  logic [CFG_W-1:0]     col_q;
  logic                 rowmode_q;
  logic [ENTRY_W-1:0]   wval_q;
  logic [COUNT_W-1:0]   count_q;
  logic                 err_q;
  logic                 rel_q;
  logic                 fwd_q;
  logic                 bwd_q;
  result_t              out_q;
  logic                 out_valid_q;

  op_e                  in_op;
  logic [ITEM_W-1:0]    in_f1;
  logic [ITEM_W-1:0]    in_f2;
  logic                 in_row;
  logic [CFG_W-1:0]     lim;
  logic                 in_err;
  logic [AW-1:0]        addr_fwd;
  logic [AW-1:0]        addr_mir;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [ENTRY_W-1:0]   new_val;
  logic                 last_col;
  logic                 count_add;
  logic                 out_load;

  assign in_op = op_e'(s_tdata_i[2:0]);
  assign in_f1 = s_tdata_i[8:3];
  assign in_f2 = s_tdata_i[14:9];

  // A query of equal indices reads the diagonal entry, not the whole row.
  assign in_row = (in_f1 == in_f2) && (in_op != OP_QUERY);

  assign lim    = (items_q > CFG_W'(LIM)) ? CFG_W'(LIM) : items_q;
  assign in_err = ({1'b0, in_f1} >= lim) || ({1'b0, in_f2} >= lim);

  // Indices are known to be below the item count here, so the casts only
  // drop zero bits.
  assign addr_fwd = AW'(row_q) * AW'(MAX_ITEMS) + AW'(col_q);
  assign addr_mir = AW'(col_q) * AW'(MAX_ITEMS) + AW'(row_q);

  always_comb begin
    case (op_q)
      OP_ADD:     new_val = RELATED_BIT;
      OP_SET_FWD: new_val = (ram_rdata != '0) ? (ram_rdata | FORWARD_BIT) : ram_rdata;
      OP_SET_BWD: new_val = (ram_rdata != '0) ? (ram_rdata | BACKWARD_BIT) : ram_rdata;
      default:    new_val = ram_rdata;
    endcase
  end

  assign last_col  = !rowmode_q || (col_q == lim - 7'd1);
  assign count_add = (op_q == OP_ADD) && (ram_rdata == '0) && (col_q != {1'b0, row_q});
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || m_tready_i);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_mir;
    ram_wdata = wval_q;
    case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_MOD: begin
        ram_we    = (op_q != OP_QUERY);
        ram_waddr = addr_fwd;
        ram_wdata = new_val;
      end
      ST_MIR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  srms_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(addr_fwd),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      items_q     <= ITEMS_RESET;
      op_q        <= OP_ADD;
      row_q       <= '0;
      col_q       <= '0;
      rowmode_q   <= 1'b0;
      wval_q      <= '0;
      count_q     <= '0;
      err_q       <= 1'b0;
      rel_q       <= 1'b0;
      fwd_q       <= 1'b0;
      bwd_q       <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        items_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLR: begin
          if (clr_q == AW'(DEPTH - 1)) begin
            clr_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= pend_q ? ST_OUT : ST_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_tvalid_i) begin
            op_q      <= in_op;
            row_q     <= in_f1;
            rowmode_q <= in_row;
            col_q     <= in_row ? '0 : {1'b0, in_f2};
            err_q     <= 1'b0;
            rel_q     <= 1'b0;
            fwd_q     <= 1'b0;
            bwd_q     <= 1'b0;
            case (in_op)
              OP_CLEAR: begin
                count_q <= '0;
                pend_q  <= 1'b1;
                state_q <= ST_CLR;
              end
              OP_ADD, OP_SET_FWD, OP_SET_BWD, OP_QUERY: begin
                if (in_err) begin
                  err_q   <= 1'b1;
                  state_q <= ST_OUT;
                end else begin
                  state_q <= ST_RD;
                end
              end
              default: begin
                state_q <= ST_OUT;
              end
            endcase
          end
        end
        ST_RD: begin
          state_q <= ST_MOD;
        end
        ST_MOD: begin
          if (op_q == OP_QUERY) begin
            rel_q   <= ram_rdata[0];
            fwd_q   <= ram_rdata[1];
            bwd_q   <= ram_rdata[2];
            state_q <= ST_OUT;
          end else begin
            wval_q <= new_val;
            if (count_add && (count_q != COUNT_MAX)) begin
              count_q <= count_q + 1'b1;
            end
            state_q <= ST_MIR;
          end
        end
        ST_MIR: begin
          if (last_col) begin
            state_q <= ST_OUT;
          end else begin
            col_q   <= col_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_q.err   <= err_q;
            out_q.rel   <= rel_q;
            out_q.fwd   <= fwd_q;
            out_q.bwd   <= bwd_q;
            out_q.count <= count_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {1'b0, out_q};

endmodule

`default_nettype wire
